>>> rtl/mgeb_pkg.sv
// Shared types and constants of the monochrome glyph expansion blit.
package mgeb_pkg;

   localparam int LANE_COUNT     = 8;
   localparam int LANE_SEL_WIDTH = $clog2(LANE_COUNT);
   localparam int INDEX_WIDTH    = 19;
   localparam int CSR_IDX_WIDTH  = 3;
   localparam int CSR_DATA_WIDTH = 32;

   localparam logic [9:0]  WIN_WIDTH_RESET    = 10'd800;
   localparam logic [8:0]  WIN_HEIGHT_RESET   = 9'd480;
   localparam logic [15:0] GLYPH_WIDTH_RESET  = 16'd8;
   localparam logic [15:0] GLYPH_HEIGHT_RESET = 16'd8;
   localparam logic [31:0] FORE_COLOR_RESET   = 32'hFFFF_FFFF;
   localparam logic [15:0] ROW_COUNT_MAX      = 16'hFFFF;

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_WIN_WIDTH    = 3'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_WIN_HEIGHT   = 3'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_GLYPH_WIDTH  = 3'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_GLYPH_HEIGHT = 3'd3;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_DRAW_X       = 3'd4;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_DRAW_Y       = 3'd5;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_FORE_COLOR   = 3'd6;

   typedef struct packed {
      logic [7:0] bitmap_byte;
      logic       glyph_start;
   } req_payload_type;

   typedef struct packed {
      logic [INDEX_WIDTH-1:0] pixel_index;
      logic [31:0]            pixel_value;
      logic                   offset_error;
      logic                   last_of_byte;
   } rsp_payload_type;

   // Per-byte context handed from the front end to the lanes
   typedef struct packed {
      logic [INDEX_WIDTH-1:0] row_base;
      logic [12:0]            byte_column;
      logic [31:0]            fore_color;
      logic [7:0]             bits;
      logic [9:0]             x_lim;
      logic                   draw;
      logic                   offset_error;
   } ctx_type;

   typedef struct packed {
      logic                   en;
      logic [INDEX_WIDTH-1:0] pixel_index;
      logic [31:0]            pixel_value;
      logic                   offset_error;
   } lane_out_type;

endpackage

>>> rtl/mgeb_ctrl.sv
// Front end: configuration registers, glyph row/column counters and byte context.
module mgeb_ctrl
   import mgeb_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [CSR_IDX_WIDTH-1:0]  csr_index,
   input  logic [CSR_DATA_WIDTH-1:0] csr_wdata,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_payload_type           req_data,
   input  logic                      ctx_take,
   output logic                      ctx_valid,
   output ctx_type                   ctx
);

   logic [9:0]  win_width_ff;
   logic [8:0]  win_height_ff;
   logic [15:0] glyph_width_ff;
   logic [15:0] glyph_height_ff;
   logic [9:0]  draw_x_ff;
   logic [8:0]  draw_y_ff;
   logic [31:0] fore_color_ff;

   logic [15:0]            row_count_ff, row_count_in;
   logic [12:0]            byte_column_ff, byte_column_in;
   logic [INDEX_WIDTH-1:0] row_base_ff, row_base_in;
   logic                   ctx_valid_ff;
   ctx_type                ctx_ff, ctx_in;

   logic                   accept;
   logic [INDEX_WIDTH-1:0] start_prod;
   logic [INDEX_WIDTH-1:0] base_eff;
   logic [12:0]            col_eff;
   logic [15:0]            row_eff;
   logic                   off_err;
   logic [16:0]            width_sum;
   logic [13:0]            row_bytes;
   logic [9:0]             x_rem;
   logic [8:0]             y_rem;
   logic [9:0]             x_lim;
   logic [8:0]             y_lim;
   logic [13:0]            col_next;

   assign req_stall = ctx_valid_ff && !ctx_take;
   assign accept    = req_valid && !req_stall;
   assign ctx_valid = ctx_valid_ff;
   assign ctx       = ctx_ff;

   always_comb begin
      start_prod = INDEX_WIDTH'(draw_y_ff) * INDEX_WIDTH'(win_width_ff);
      base_eff   = row_base_ff;
      col_eff    = byte_column_ff;
      row_eff    = row_count_ff;
      if (req_data.glyph_start) begin
         base_eff = start_prod + INDEX_WIDTH'(draw_x_ff);
         col_eff  = '0;
         row_eff  = '0;
      end

      off_err   = (draw_x_ff > win_width_ff) || (draw_y_ff > win_height_ff);
      width_sum = {1'b0, glyph_width_ff} + 17'd7;
      row_bytes = width_sum[16:3];
      x_rem     = win_width_ff - draw_x_ff;
      y_rem     = win_height_ff - draw_y_ff;
      x_lim     = (glyph_width_ff < {6'd0, x_rem}) ? glyph_width_ff[9:0] : x_rem;
      y_lim     = (glyph_height_ff < {7'd0, y_rem}) ? glyph_height_ff[8:0] : y_rem;
      col_next  = {1'b0, col_eff} + 14'd1;

      row_base_in    = base_eff;
      byte_column_in = col_eff;
      row_count_in   = row_eff;
      // Offset error and zero glyph width keep the counters from advancing
      if (!off_err && row_bytes != '0) begin
         if (col_next >= row_bytes) begin
            byte_column_in = '0;
            row_count_in   = (row_eff == ROW_COUNT_MAX) ? row_eff : row_eff + 16'd1;
            row_base_in    = base_eff + INDEX_WIDTH'(win_width_ff);
         end else begin
            byte_column_in = col_next[12:0];
         end
      end

      ctx_in.row_base     = base_eff;
      ctx_in.byte_column  = col_eff;
      ctx_in.fore_color   = fore_color_ff;
      ctx_in.bits         = req_data.bitmap_byte;
      ctx_in.x_lim        = x_lim;
      ctx_in.draw         = !off_err && row_bytes != '0 && row_eff < {7'd0, y_lim};
      ctx_in.offset_error = off_err;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_width_ff    <= WIN_WIDTH_RESET;
         win_height_ff   <= WIN_HEIGHT_RESET;
         glyph_width_ff  <= GLYPH_WIDTH_RESET;
         glyph_height_ff <= GLYPH_HEIGHT_RESET;
         draw_x_ff       <= '0;
         draw_y_ff       <= '0;
         fore_color_ff   <= FORE_COLOR_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_WIN_WIDTH:    win_width_ff    <= csr_wdata[9:0];
            CSR_WIN_HEIGHT:   win_height_ff   <= csr_wdata[8:0];
            CSR_GLYPH_WIDTH:  glyph_width_ff  <= csr_wdata[15:0];
            CSR_GLYPH_HEIGHT: glyph_height_ff <= csr_wdata[15:0];
            CSR_DRAW_X:       draw_x_ff       <= csr_wdata[9:0];
            CSR_DRAW_Y:       draw_y_ff       <= csr_wdata[8:0];
            CSR_FORE_COLOR:   fore_color_ff   <= csr_wdata[31:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff   <= '0;
         byte_column_ff <= '0;
         row_base_ff    <= '0;
         ctx_valid_ff   <= 1'b0;
      end else begin
         if (accept) begin
            row_count_ff   <= row_count_in;
            byte_column_ff <= byte_column_in;
            row_base_ff    <= row_base_in;
            ctx_valid_ff   <= 1'b1;
         end else if (ctx_take) begin
            ctx_valid_ff   <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ctx_ff <= ctx_in;
      end
   end

endmodule

>>> rtl/mgeb_lane.sv
// One pixel lane: index, colour and clip test for one bit of the byte.
module mgeb_lane
   import mgeb_pkg::*;
(
   input  ctx_type                   ctx,
   input  logic [LANE_SEL_WIDTH-1:0] lane_sel,
   output lane_out_type              lane_out
);

   logic [15:0]               x;
   logic [LANE_SEL_WIDTH-1:0] bit_sel;

   always_comb begin
      x       = {ctx.byte_column, lane_sel};
      bit_sel = LANE_SEL_WIDTH'(LANE_COUNT - 1) - lane_sel;
      if (ctx.offset_error) begin
         // Error word goes out on the leftmost lane only
         lane_out.en           = (lane_sel == '0);
         lane_out.pixel_index  = '0;
         lane_out.pixel_value  = '0;
         lane_out.offset_error = 1'b1;
      end else begin
         lane_out.en           = ctx.draw && (x < {6'd0, ctx.x_lim});
         lane_out.pixel_index  = ctx.row_base + INDEX_WIDTH'(x);
         lane_out.pixel_value  = ctx.bits[bit_sel] ? ctx.fore_color : 32'd0;
         lane_out.offset_error = 1'b0;
      end
   end

endmodule

>>> rtl/mgeb_merge.sv
// Merge stage: holds one byte's lane results and sends them out leftmost first.
module mgeb_merge
   import mgeb_pkg::*;
(
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           ctx_valid,
   output logic                           ctx_take,
   input  lane_out_type [LANE_COUNT-1:0]  lane_out,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output rsp_payload_type                rsp_data
);

   logic [LANE_COUNT-1:0]         mask_ff, mask_in;
   lane_out_type [LANE_COUNT-1:0] bank_ff;
   logic                          out_valid_ff, out_valid_in;
   rsp_payload_type               out_ff, out_in;

   logic                      out_free;
   logic                      pop;
   logic [LANE_SEL_WIDTH-1:0] pop_idx;
   logic [LANE_COUNT-1:0]     pop_bit;
   logic [LANE_COUNT-1:0]     rest;
   logic                      load;

   always_comb begin
      // Lowest set lane is the leftmost pixel still waiting
      pop_idx = '0;
      for (int i = LANE_COUNT - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            pop_idx = LANE_SEL_WIDTH'(i);
         end
      end
      pop_bit  = LANE_COUNT'(1) << pop_idx;
      rest     = mask_ff & ~pop_bit;
      out_free = !out_valid_ff || !rsp_stall;
      pop      = out_free && (mask_ff != '0);
      ctx_take = ctx_valid && ((mask_ff == '0) || (pop && rest == '0));
      load     = ctx_take;

      mask_in = pop ? rest : mask_ff;
      if (load) begin
         for (int i = 0; i < LANE_COUNT; i++) begin
            mask_in[i] = lane_out[i].en;
         end
      end

      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (pop) begin
         out_valid_in        = 1'b1;
         out_in.pixel_index  = bank_ff[pop_idx].pixel_index;
         out_in.pixel_value  = bank_ff[pop_idx].pixel_value;
         out_in.offset_error = bank_ff[pop_idx].offset_error;
         out_in.last_of_byte = (rest == '0);
      end else if (out_free) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         mask_ff      <= mask_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      if (load) begin
         bank_ff <= lane_out;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

>>> rtl/mono_glyph_expand_blit_core.sv
// Top level of the monochrome glyph expansion blit.
//
// Input channel req_*: one bitmap byte per word, bit 7 leftmost, with
// glyph_start marking the first byte of a glyph. Result channel rsp_*: one
// pixel write per word (window index, colour or zero), leftmost pixel first,
// last_of_byte set on the final word of each byte. An offset beyond the window
// gives a single error word per byte; a fully clipped byte gives no word.
// Configuration: csr_wr_en, csr_index, csr_wdata write the window, glyph,
// offset and colour registers; write them only while the block is idle.
// Path: a taken byte is registered in the front end's context register, then in
// the merge stage's lane bank, then each word in its single output register.
// Throughput: one result word per cycle while rsp_stall is low. Eight lanes
// evaluate a byte's pixels at once and the next byte is taken while the
// current one drains.
// Reset: registers return to an 800 x 480 window, 8 x 8 glyph at the origin,
// white foreground; counters and all buffered words clear.
// rsp_stall holds the output word; bytes back up and req_stall rises.
module mono_glyph_expand_blit_core
   import mgeb_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [CSR_IDX_WIDTH-1:0]  csr_index,
   input  logic [CSR_DATA_WIDTH-1:0] csr_wdata,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_payload_type           req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_payload_type           rsp_data
);

   logic                          ctx_valid;
   logic                          ctx_take;
   ctx_type                       ctx;
   lane_out_type [LANE_COUNT-1:0] lane_out;

   mgeb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .ctx_take  (ctx_take),
      .ctx_valid (ctx_valid),
      .ctx       (ctx)
   );

   for (genvar g = 0; g < LANE_COUNT; g++) begin : g_lane
      mgeb_lane u_lane (
         .ctx      (ctx),
         .lane_sel (LANE_SEL_WIDTH'(g)),
         .lane_out (lane_out[g])
      );
   end

   mgeb_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .ctx_valid (ctx_valid),
      .ctx_take  (ctx_take),
      .lane_out  (lane_out),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

>>> sim/tb_mono_glyph_expand_blit_core.sv
// Self-checking testbench for the monochrome glyph expansion blit core.
`timescale 1ns / 100ps

module tb_mono_glyph_expand_blit_core;
   import mgeb_pkg::*;

   localparam int DRAIN_CYCLES = 16;
   // Worst case is roughly 450 bytes x 8 words, each word stalled for a while.
   localparam int CYCLE_LIMIT  = 500000;
   localparam int IDLE_PERCENT = 12;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_wr_en = 1'b0;
   logic [CSR_IDX_WIDTH-1:0]  csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_wdata = '0;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   req_payload_type           req_data = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   rsp_payload_type           rsp_data;

   // Shadow of the block's registers and counters
   logic [9:0]  win_width    = WIN_WIDTH_RESET;
   logic [8:0]  win_height   = WIN_HEIGHT_RESET;
   logic [15:0] glyph_width  = GLYPH_WIDTH_RESET;
   logic [15:0] glyph_height = GLYPH_HEIGHT_RESET;
   logic [9:0]  draw_x       = '0;
   logic [8:0]  draw_y       = '0;
   logic [31:0] fore_color   = FORE_COLOR_RESET;
   logic [15:0] row_count      = '0;
   logic [12:0] byte_column    = '0;
   logic [18:0] row_base_index = '0;

   req_payload_type pending_bytes[$];
   rsp_payload_type expected_pixels[$];

   logic calm        = 1'b0;
   logic hold_sender = 1'b0;
   int   fail_count  = 0;
   int   cycle_count = 0;

   mono_glyph_expand_blit_core dut (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // Work out the pixel words one bitmap byte causes and advance the counters.
   task automatic predict_pixels(input req_payload_type w);
      logic [31:0] ww, sum, row_bytes, x_lim, y_lim, col_lim, line_lim, x;
      rsp_payload_type lane_words [8];
      int n, b, i;
      ww = {22'd0, win_width};
      n = 0;
      if (w.glyph_start) begin
         row_count   = '0;
         byte_column = '0;
         sum = {23'd0, draw_y} * ww + {22'd0, draw_x};
         row_base_index = sum[18:0];
      end
      if (draw_x > win_width || draw_y > win_height) begin
         lane_words[0] = '0;
         lane_words[0].offset_error = 1'b1;
         lane_words[0].last_of_byte = 1'b1;
         expected_pixels.push_back(lane_words[0]);
      end else if (glyph_width != 16'd0) begin
         row_bytes = ({16'd0, glyph_width} + 32'd7) >> 3;
         col_lim   = ww - {22'd0, draw_x};
         line_lim  = {23'd0, win_height} - {23'd0, draw_y};
         x_lim = ({16'd0, glyph_width} < col_lim) ? {16'd0, glyph_width} : col_lim;
         y_lim = ({16'd0, glyph_height} < line_lim) ? {16'd0, glyph_height} : line_lim;
         if ({16'd0, row_count} < y_lim) begin
            for (b = 0; b < 8; b++) begin
               x = {16'd0, byte_column, 3'b000} + b;
               if (x < x_lim) begin
                  sum = {13'd0, row_base_index} + x;
                  lane_words[n] = '0;
                  lane_words[n].pixel_index = sum[18:0];
                  lane_words[n].pixel_value = w.bitmap_byte[7-b] ? fore_color : 32'd0;
                  n++;
               end
            end
            for (i = 0; i < n; i++) begin
               lane_words[i].last_of_byte = (i == n - 1);
               expected_pixels.push_back(lane_words[i]);
            end
         end
         if ({19'd0, byte_column} + 32'd1 >= row_bytes) begin
            byte_column = '0;
            if (row_count != ROW_COUNT_MAX)
               row_count = row_count + 16'd1;
            row_base_index = row_base_index + {9'd0, win_width};
         end else begin
            byte_column = byte_column + 13'd1;
         end
      end
   endtask

   // Driver: offer the oldest pending byte, hold it while stalled.
   always @(posedge clock) begin : drive_bytes
      req_payload_type taken;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_pixels(req_data);
            taken = pending_bytes.pop_front();
         end
         if (req_valid && req_stall) begin
            // hold the stalled word
         end else if (pending_bytes.size() != 0 && !hold_sender &&
                      (calm || $urandom_range(99) >= IDLE_PERCENT)) begin
            req_valid <= 1'b1;
            req_data  <= pending_bytes[0];
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: check each accepted pixel word against the oldest expectation.
   always @(posedge clock) begin : check_pixels
      rsp_payload_type want;
      logic bad;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_pixels.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected pixel word: idx %0d val %h err %b last %b",
                           rsp_data.pixel_index, rsp_data.pixel_value,
                           rsp_data.offset_error, rsp_data.last_of_byte);
               fail_count++;
            end else begin
               want = expected_pixels.pop_front();
               bad = (rsp_data.pixel_index !== want.pixel_index) ||
                     (rsp_data.pixel_value !== want.pixel_value) ||
                     (rsp_data.offset_error !== want.offset_error) ||
                     (rsp_data.last_of_byte !== want.last_of_byte);
               if (bad) begin
                  if (fail_count < 10)
                     $display("pixel word mismatch: want idx %0d val %h err %b last %b, got idx %0d val %h err %b last %b",
                              want.pixel_index, want.pixel_value, want.offset_error,
                              want.last_of_byte, rsp_data.pixel_index, rsp_data.pixel_value,
                              rsp_data.offset_error, rsp_data.last_of_byte);
                  fail_count++;
               end
            end
         end
         rsp_stall <= !calm && ($urandom_range(99) < IDLE_PERCENT);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic write_reg(input logic [CSR_IDX_WIDTH-1:0] idx, input logic [31:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_WIN_WIDTH:    win_width    = value[9:0];
         CSR_WIN_HEIGHT:   win_height   = value[8:0];
         CSR_GLYPH_WIDTH:  glyph_width  = value[15:0];
         CSR_GLYPH_HEIGHT: glyph_height = value[15:0];
         CSR_DRAW_X:       draw_x       = value[9:0];
         CSR_DRAW_Y:       draw_y       = value[8:0];
         CSR_FORE_COLOR:   fore_color   = value;
         default: ;
      endcase
   endtask

   // Write every register; unused upper bits carry noise that the block must drop.
   task automatic apply_settings(input int unsigned ww, wh, gw, gh, dx, dy, fc);
      write_reg(CSR_WIN_WIDTH,    ($urandom() & ~32'h3FF)  | (ww & 32'h3FF));
      write_reg(CSR_WIN_HEIGHT,   ($urandom() & ~32'h1FF)  | (wh & 32'h1FF));
      write_reg(CSR_GLYPH_WIDTH,  ($urandom() & ~32'hFFFF) | (gw & 32'hFFFF));
      write_reg(CSR_GLYPH_HEIGHT, ($urandom() & ~32'hFFFF) | (gh & 32'hFFFF));
      write_reg(CSR_DRAW_X,       ($urandom() & ~32'h3FF)  | (dx & 32'h3FF));
      write_reg(CSR_DRAW_Y,       ($urandom() & ~32'h1FF)  | (dy & 32'h1FF));
      write_reg(CSR_FORE_COLOR,   fc);
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic push_byte(input logic [7:0] bits, input logic start);
      req_payload_type w;
      w.bitmap_byte = bits;
      w.glyph_start = start;
      pending_bytes.push_back(w);
   endtask

   // Wait until every byte is taken and every word has come, then let the pipe settle.
   task automatic wait_drained();
      while (pending_bytes.size() != 0 || req_valid || expected_pixels.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [7:0] pick_bits();
      case ($urandom_range(7))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   task automatic random_settings();
      int unsigned ww, wh, gw, gh, dx, dy, fc;
      case ($urandom_range(9))
         0:       ww = 1;
         1:       ww = 800;
         2:       ww = 1023;
         default: ww = $urandom_range(800, 1);
      endcase
      case ($urandom_range(9))
         0:       wh = 1;
         1:       wh = 480;
         2:       wh = 511;
         default: wh = $urandom_range(480, 1);
      endcase
      case ($urandom_range(9))
         0:       dx = 0;
         1:       dx = ww;
         2:       dx = (ww < 1023) ? $urandom_range(1023, ww + 1) : ww;
         default: dx = (ww > 16) ? $urandom_range(ww, ww - 16) : $urandom_range(ww, 0);
      endcase
      case ($urandom_range(9))
         0:       dy = 0;
         1:       dy = wh;
         2:       dy = (wh < 511) ? $urandom_range(511, wh + 1) : wh;
         default: dy = $urandom_range(wh, 0);
      endcase
      case ($urandom_range(9))
         0:       gw = 0;
         1:       gw = 65535;
         2:       gw = $urandom_range(65535, 25);
         default: gw = $urandom_range(24, 1);
      endcase
      case ($urandom_range(9))
         0:       gh = 0;
         1:       gh = 65535;
         default: gh = $urandom_range(12, 1);
      endcase
      case ($urandom_range(5))
         0:       fc = 32'h0;
         1:       fc = 32'hFFFF_FFFF;
         default: fc = $urandom();
      endcase
      apply_settings(ww, wh, gw, gh, dx, dy, fc);
   endtask

   // Mostly whole glyphs with random content, some truncated glyphs and loose bytes.
   task automatic random_items(input int count);
      int left, glyph_len, k;
      left = count;
      while (left > 0) begin
         if ($urandom_range(99) < 85) begin
            glyph_len = ((int'(glyph_width) + 7) >> 3) * int'(glyph_height);
            if (glyph_len < 1)
               glyph_len = 1;
            if (glyph_len > left)
               glyph_len = left;
            if ($urandom_range(9) == 0)
               glyph_len = $urandom_range(glyph_len, 1);
            for (k = 0; k < glyph_len; k++)
               push_byte(pick_bits(), k == 0);
            left -= glyph_len;
         end else begin
            push_byte(pick_bits(), 1'($urandom_range(1)));
            left--;
         end
      end
   endtask

   initial begin : stimulus
      int phase;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Reset settings, bytes before any glyph start, then a fresh glyph
      push_byte(8'hFF, 1'b0);
      push_byte(8'h80, 1'b0);
      push_byte(8'hA5, 1'b1);
      push_byte(8'h00, 1'b0);
      push_byte(8'h01, 1'b0);
      wait_drained();

      // Two bytes per row, second one clipped at the glyph width, then past the height
      apply_settings(800, 480, 12, 3, 0, 0, 32'h1234_5678);
      push_byte(8'hFF, 1'b1);
      push_byte(8'hFF, 1'b0);
      push_byte(8'h5A, 1'b0);
      push_byte(8'hC3, 1'b0);
      push_byte(8'h81, 1'b0);
      push_byte(8'h7E, 1'b0);
      push_byte(8'hFF, 1'b0);
      wait_drained();

      // Clip against the window edges
      apply_settings(10, 2, 16, 4, 5, 1, 32'h0);
      push_byte(8'hFF, 1'b1);
      push_byte(8'h55, 1'b0);
      push_byte(8'hAA, 1'b0);
      wait_drained();

      // Offset beyond the window, horizontally then vertically
      apply_settings(100, 50, 8, 8, 101, 0, 32'hDEAD_BEEF);
      push_byte(8'hFF, 1'b1);
      push_byte(8'h0F, 1'b0);
      wait_drained();
      apply_settings(100, 50, 8, 8, 0, 51, 32'hDEAD_BEEF);
      push_byte(8'hF0, 1'b0);
      wait_drained();

      // Zero glyph width
      apply_settings(800, 480, 0, 8, 3, 3, 32'hCAFE_F00D);
      push_byte(8'hFF, 1'b1);
      push_byte(8'hFF, 1'b0);
      wait_drained();

      // Bottom-right corner of the full window with the widest glyph
      apply_settings(800, 480, 65535, 65535, 792, 479, 32'hFFFF_FFFF);
      push_byte(8'h96, 1'b1);
      push_byte(8'hFF, 1'b0);
      wait_drained();

      // Smallest window and glyph
      apply_settings(1, 1, 1, 1, 0, 0, 32'h8000_0001);
      push_byte(8'h80, 1'b1);
      push_byte(8'h7F, 1'b1);
      wait_drained();

      for (phase = 0; phase < 12; phase++) begin
         random_settings();
         calm = (phase == 3);
         if (phase == 6) begin
            random_items(18);
            while (pending_bytes.size() != 0 || req_valid)
               @(posedge clock);
            // hold the sender until every expected word has come back
            hold_sender = 1'b1;
            random_items(18);
            while (expected_pixels.size() != 0)
               @(posedge clock);
            hold_sender = 1'b0;
         end else begin
            random_items(36);
         end
         wait_drained();
      end
      calm = 1'b0;

      if (expected_pixels.size() != 0) begin
         $display("%0d pixel words never arrived", expected_pixels.size());
         fail_count++;
      end
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

>>> filelist.f
rtl/mgeb_pkg.sv
rtl/mgeb_ctrl.sv
rtl/mgeb_lane.sv
rtl/mgeb_merge.sv
rtl/mono_glyph_expand_blit_core.sv
sim/tb_mono_glyph_expand_blit_core.sv
